// ===== sv/gf256_pkg.sv =====
package gf256_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_NEG = 2'd2,
    OP_INV = 2'd3
  } op_t;

  localparam logic [8:0] POLY    = 9'h11B;
  localparam logic [7:0] INV_EXP = 8'hFE;

  typedef logic [255:0][7:0] inv_table_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] acc;
    x   = a;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      if (x[7]) begin
        x = {x[6:0], 1'b0} ^ POLY[7:0];
      end else begin
        x = {x[6:0], 1'b0};
      end
    end
    return acc;
  endfunction

  // a^254 for every element; zero maps to zero
  function automatic inv_table_t build_inv_table();
    inv_table_t tbl;
    logic [7:0] r;
    logic [7:0] e;
    tbl = '0;
    for (int i = 0; i < 256; i++) begin
      e = 8'(i);
      r = 8'd1;
      for (int k = 7; k >= 0; k--) begin
        r = gf_mul(r, r);
        if (INV_EXP[k]) begin
          r = gf_mul(r, e);
        end
      end
      tbl[e] = r;
    end
    return tbl;
  endfunction

  localparam inv_table_t INV_TABLE = build_inv_table();

endpackage

// ===== sv/gf256_alu.sv =====
module gf256_alu
  import gf256_pkg::*;
(
  input  op_t        op,
  input  logic [7:0] a,
  input  logic [7:0] b,
  output logic [7:0] result
);

  logic [7:0] product;

  assign product = gf_mul(a, b);

  always_comb begin
    unique case (op)
      OP_ADD:  result = a ^ b;
      OP_MUL:  result = product;
      OP_NEG:  result = a;
      OP_INV:  result = INV_TABLE[a];
      default: result = a;
    endcase
  end

endmodule

// ===== sv/gf256_arithmetic_unit.sv =====
// channel   | handshake              | payload
// ----------+------------------------+--------------------------------------
// request   | req_valid / req_stall  | operation, operand_a, operand_b
// response  | rsp_valid / rsp_stall  | value_out
//
// Operand register, then result register after the ALU.
// One beat per cycle sustained while rsp_stall is low; the table lookup and eight-step multiply set the path.
// Synchronous reset empties both stages; no other state.
// A stalled response holds; the operand stage still takes one more beat if it is empty.
module gf256_arithmetic_unit
  import gf256_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] operation,
  input  logic [7:0] operand_a,
  input  logic [7:0] operand_b,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] value_out
);

  logic       s1_valid;
  op_t        s1_op;
  logic [7:0] s1_a;
  logic [7:0] s1_b;
  logic       s1_en;
  logic       s2_en;
  logic [7:0] alu_result;

  assign s2_en     = !rsp_valid || !rsp_stall;
  assign s1_en     = !s1_valid || s2_en;
  assign req_stall = !s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && req_valid) begin
      s1_op <= op_t'(operation);
      s1_a  <= operand_a;
      s1_b  <= operand_b;
    end
  end

  gf256_alu u_alu (
    .op     (s1_op),
    .a      (s1_a),
    .b      (s1_b),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s2_en) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid) begin
      value_out <= alu_result;
    end
  end

endmodule

// ===== sv/gf256_checker.sv =====
module gf256_checker
  import gf256_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_stall,
  input logic [1:0] operation,
  input logic [7:0] operand_a,
  input logic [7:0] operand_b,
  input logic       rsp_valid,
  input logic       rsp_stall,
  input logic [7:0] value_out
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(value_out))
    else $error("stalled response beat changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_add_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && operation == OP_ADD) ##1 !rsp_stall
      |=> rsp_valid && value_out == $past(operand_a ^ operand_b, 2))
    else $error("add beat lost or wrong");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!req_valid && !rsp_stall) ##1 !rsp_stall |=> !rsp_valid)
    else $error("response beat invented");

endmodule

bind gf256_arithmetic_unit gf256_checker u_chk (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import gf256_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_PER_PHASE = 233;
  localparam int NUM_PHASES       = 4;
  localparam int SETTLE_CYCLES    = 8;

  typedef struct packed {
    op_t        op;
    logic [7:0] a;
    logic [7:0] b;
  } gf_request_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  op_t        operation = OP_ADD;
  logic [7:0] operand_a = '0;
  logic [7:0] operand_b = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic [7:0] value_out;

  gf_request_t request_q[$];
  logic [7:0]  field_value_q[$];
  logic        req_fired      = 1'b0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          error_count    = 0;
  int          cycle_count    = 0;

  always #1 clk = ~clk;

  gf256_arithmetic_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .value_out (value_out)
  );

  // full carry-less product, then fold the high byte down by 0x11b
  function automatic logic [7:0] field_product(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] prod;
    prod = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        prod = prod ^ ({8'h00, a} << i);
      end
    end
    for (int i = 15; i >= 8; i--) begin
      if (prod[i]) begin
        prod = prod ^ (16'h011B << (i - 8));
      end
    end
    return prod[7:0];
  endfunction

  function automatic logic [7:0] field_reciprocal(input logic [7:0] a);
    logic [7:0] r;
    r = 8'h00;
    for (int c = 1; c < 256; c++) begin
      if (field_product(a, 8'(c)) == 8'h01) begin
        r = 8'(c);
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] field_result(input gf_request_t req);
    logic [7:0] r;
    case (req.op)
      OP_ADD: begin
        r = req.a ^ req.b;
      end
      OP_MUL: begin
        r = field_product(req.a, req.b);
      end
      OP_NEG: begin
        r = req.a;
      end
      default: begin
        r = field_reciprocal(req.a);
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pick_operand();
    logic [7:0] v;
    case ($urandom_range(7))
      0: v = 8'h00;
      1: v = 8'hFF;
      2: v = 8'h01;
      default: v = 8'($urandom);
    endcase
    return v;
  endfunction

  task automatic queue_request(input op_t op, input logic [7:0] a, input logic [7:0] b);
    gf_request_t req;
    req.op = op;
    req.a  = a;
    req.b  = b;
    request_q.push_back(req);
  endtask

  task automatic wait_for_drain();
    while (request_q.size() != 0 || req_valid || field_value_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    gf_request_t taken;
    logic [7:0]  expected;
    if (rst) begin
      req_fired <= 1'b0;
    end else begin
      req_fired <= req_valid && !req_stall;
      if (req_valid && !req_stall) begin
        taken.op = operation;
        taken.a  = operand_a;
        taken.b  = operand_b;
        field_value_q.push_back(field_result(taken));
      end
      if (rsp_valid && !rsp_stall) begin
        if (field_value_q.size() == 0) begin
          $error("value_out: expected none, actual %02h", value_out);
          error_count++;
        end else begin
          expected = field_value_q.pop_front();
          if (value_out !== expected) begin
            $error("value_out: expected %02h, actual %02h", expected, value_out);
            error_count++;
          end
        end
      end
    end
  end

  // hold a stalled beat, advance once it fires
  always @(negedge clk) begin : driver
    gf_request_t next_req;
    if (rst) begin
      req_valid <= 1'b0;
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!req_valid || req_fired) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = request_q.pop_front();
          req_valid <= 1'b1;
          operation <= next_req.op;
          operand_a <= next_req.a;
          operand_b <= next_req.b;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    int send_pct[NUM_PHASES];
    int recv_pct[NUM_PHASES];
    send_pct = '{0, 54, 0, 38};
    recv_pct = '{0, 0, 54, 38};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_request(OP_ADD, 8'h00, 8'h00);
    queue_request(OP_ADD, 8'hFF, 8'hFF);
    queue_request(OP_ADD, 8'hAA, 8'h55);
    queue_request(OP_ADD, 8'hFF, 8'h00);
    queue_request(OP_MUL, 8'h00, 8'hFF);
    queue_request(OP_MUL, 8'h01, 8'hC3);
    queue_request(OP_MUL, 8'hFF, 8'hFF);
    queue_request(OP_MUL, 8'h80, 8'h02);
    queue_request(OP_MUL, 8'h53, 8'hCA);
    queue_request(OP_MUL, 8'h57, 8'h83);
    queue_request(OP_NEG, 8'h00, 8'hFF);
    queue_request(OP_NEG, 8'hFF, 8'h00);
    queue_request(OP_NEG, 8'h5A, 8'hA5);
    queue_request(OP_INV, 8'h00, 8'h00);
    queue_request(OP_INV, 8'h00, 8'hFF);
    queue_request(OP_INV, 8'h01, 8'h7E);
    queue_request(OP_INV, 8'hFF, 8'hFF);
    queue_request(OP_INV, 8'h53, 8'h00);
    queue_request(OP_INV, 8'h80, 8'h3C);
    wait_for_drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        queue_request(op_t'($urandom_range(3)), pick_operand(), pick_operand());
      end
      wait_for_drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/gf256_pkg.sv
sv/gf256_alu.sv
sv/gf256_arithmetic_unit.sv
sv/gf256_checker.sv
tb/tb.sv
